// ----- rtl/lfota_pkg.sv -----
// ----------------------------------------------------------------------------
// lfota_pkg
// Shared constants, register indexes and the sine table entry function for
// the LFO auto-pan block.
// ----------------------------------------------------------------------------
package lfota_pkg;

   localparam int PHASE_BITS_DEF       = 32;
   localparam int SINE_TABLE_DEPTH_DEF = 1024;
   localparam int SAMPLE_BITS_DEF      = 24;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int INCR_BITS      = 32;
   localparam int DEPTH_BITS     = 16;
   localparam int SINE_BITS      = 16;
   localparam int GAIN_BITS      = 32;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_INCREMENT = 4'd0,
      REG_MOD_DEPTH       = 4'd1
   } reg_index_type;

   localparam logic [INCR_BITS-1:0]  PHASE_INCREMENT_RESET = 32'd26844;
   localparam logic [DEPTH_BITS-1:0] MOD_DEPTH_RESET       = 16'd8192;
   localparam logic [DEPTH_BITS-1:0] FULL_DEPTH            = 16'd32768;

   localparam logic signed [GAIN_BITS-1:0] GAIN_HALF = 32'sd1073741824;

   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Sine at turn fraction u / 2^32, signed Q1.15, from a quarter-wave
   // Taylor polynomial evaluated in Q2.30.
   function automatic logic signed [SINE_BITS-1:0] sine_entry(input logic [63:0] u);
      logic [1:0]  quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] t;
      logic [63:0] s;
      logic [SINE_BITS-1:0] v;
      quad = u[31:30];
      r    = u & (Q30_ONE - 64'd1);
      x    = quad[0] ? (Q30_ONE - r) : r;
      z    = (x * HALF_PI_Q30 + (Q30_ONE >> 1)) >> 30;
      z2   = (z * z) >> 30;
      t    = Q30_ONE - z2 / 72;
      t    = Q30_ONE - ((z2 * t) >> 30) / 42;
      t    = Q30_ONE - ((z2 * t) >> 30) / 20;
      t    = Q30_ONE - ((z2 * t) >> 30) / 6;
      s    = (z * t) >> 30;
      s    = (s + (64'd1 << 14)) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      v = s[SINE_BITS-1:0];
      return quad[1] ? $signed(-v) : $signed(v);
   endfunction

endpackage

// ----- rtl/lfota_queue.sv -----
// ----------------------------------------------------------------------------
// lfota_queue
// Short first-in first-out queue between the front and back sections.
// ----------------------------------------------------------------------------
module lfota_queue #(
   parameter int WIDTH = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import lfota_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/lfota_front.sv -----
// ----------------------------------------------------------------------------
// lfota_front
// Accepts samples, tags each with its sine table index and advances the
// LFO phase accumulator.
// ----------------------------------------------------------------------------
module lfota_front #(
   parameter int PHASE_BITS       = lfota_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = lfota_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = lfota_pkg::SAMPLE_BITS_DEF,
   parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_BITS-1:0]    req_sample_in,
   input  logic [lfota_pkg::INCR_BITS-1:0]  phase_increment,
   output logic                             push_valid,
   input  logic                             push_ready,
   output logic [SAMPLE_BITS+IDX_W-1:0]     push_data
);
   import lfota_pkg::*;

   localparam int SUM_W  = (PHASE_BITS > INCR_BITS) ? PHASE_BITS : INCR_BITS;
   localparam int PROD_W = PHASE_BITS + IDX_W + 1;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SUM_W-1:0]      phase_sum;
   logic [PROD_W-1:0]     idx_full;
   logic [IDX_W-1:0]      idx;
   logic                  accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   assign idx_full  = (PROD_W'(phase_ff) * PROD_W'(SINE_TABLE_DEPTH)) >> PHASE_BITS;
   assign idx       = idx_full[IDX_W-1:0];
   assign push_data = {req_sample_in, idx};

   assign phase_sum = SUM_W'(phase_ff) + SUM_W'(phase_increment);
   assign phase_in  = accept ? phase_sum[PHASE_BITS-1:0] : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- rtl/lfota_back.sv -----
// ----------------------------------------------------------------------------
// lfota_back
// Reads the sine table, forms the two pan gains, scales the sample and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module lfota_back #(
   parameter int SINE_TABLE_DEPTH = lfota_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = lfota_pkg::SAMPLE_BITS_DEF,
   parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  logic [SAMPLE_BITS+IDX_W-1:0]      pop_data,
   input  logic [lfota_pkg::DEPTH_BITS-1:0]  mod_depth,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]     rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]     rsp_right_out
);
   import lfota_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DEPTH = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic signed [SINE_BITS-1:0]   sine_rom [SINE_TABLE_DEPTH];
   logic signed [SINE_BITS-1:0]   sine_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [GAIN_BITS-1:0]   mod_ff, mod_in;
   logic signed [PROD_W-1:0]      prod_l_ff, prod_r_ff;
   logic signed [PROD_W-1:0]      prod_l_in, prod_r_in;
   logic signed [PROD_W-1:0]      round_l, round_r;
   logic signed [GAIN_BITS-1:0]   gain_l, gain_r;
   logic [DEPTH_BITS-1:0]         depth_sat;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                          out_valid_ff, out_valid_in;
   logic                          do_pop;
   logic                          do_load;

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine_rom
      localparam logic [63:0] TURN_FRAC = (64'(g) << 32) / SINE_TABLE_DEPTH;
      assign sine_rom[g] = sine_entry(TURN_FRAC);
   end

   assign pop_ready = (state_ff == ST_IDLE);
   assign do_pop    = pop_valid && pop_ready;
   assign do_load   = (state_ff == ST_DONE) && (!out_valid_ff || rsp_ready);

   assign depth_sat = (mod_depth > FULL_DEPTH) ? FULL_DEPTH : mod_depth;
   assign mod_in    = GAIN_BITS'($signed({1'b0, depth_sat})) * GAIN_BITS'(sine_ff);

   assign gain_l    = GAIN_HALF + mod_ff;
   assign gain_r    = GAIN_HALF - mod_ff;
   assign prod_l_in = PROD_W'(sample_ff) * PROD_W'(gain_l);
   assign prod_r_in = PROD_W'(sample_ff) * PROD_W'(gain_r);

   assign round_l = (prod_l_ff + (PROD_W'(1) <<< 30)) >>> 31;
   assign round_r = (prod_r_ff + (PROD_W'(1) <<< 30)) >>> 31;

   assign out_valid_in = do_load || (out_valid_ff && !rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_DEPTH;
            end
         end
         ST_DEPTH: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (do_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         sample_ff <= pop_data[SAMPLE_BITS+IDX_W-1:IDX_W];
         sine_ff   <= sine_rom[pop_data[IDX_W-1:0]];
      end
      if (state_ff == ST_DEPTH) begin
         mod_ff <= mod_in;
      end
      if (state_ff == ST_SCALE) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (do_load) begin
         left_ff  <= round_l[SAMPLE_BITS-1:0];
         right_ff <= round_r[SAMPLE_BITS-1:0];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;

endmodule

// ----- rtl/lfo_tremolo_auto_pan_unit.sv -----
// ----------------------------------------------------------------------------
// lfo_tremolo_auto_pan_unit
// Sine LFO auto-pan: splits a mono sample into left and right words whose
// gains follow a sine LFO in opposite directions.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Word
//  req       in         req_valid/req_ready    req_sample_in
//  rsp       out        rsp_valid/rsp_ready    rsp_left_out, rsp_right_out
//  csr       in         csr_valid/csr_ready    csr_index, csr_data
//
//  In the back section a sample passes in order through the sine table read,
//  depth multiply, gain multiply and rounding into the output register.
//  The back section handles one sample at a time, taking the next only once
//  the last is in the output register; the queue lets two samples wait ahead
//  of it. Reset clears the LFO phase, the queue and the output valid flag,
//  and loads the register defaults. A stalled output holds the back section
//  in its last step while the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module lfo_tremolo_auto_pan_unit #(
   parameter int PHASE_BITS       = lfota_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = lfota_pkg::SINE_TABLE_DEPTH_DEF,
   parameter int SAMPLE_BITS      = lfota_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]        rsp_right_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lfota_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lfota_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import lfota_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int ENT_W = SAMPLE_BITS + IDX_W;

   logic [INCR_BITS-1:0]  phase_increment_ff, phase_increment_in;
   logic [DEPTH_BITS-1:0] mod_depth_ff, mod_depth_in;
   logic                  csr_write;
   logic                  push_valid, push_ready;
   logic [ENT_W-1:0]      push_data;
   logic                  pop_valid, pop_ready;
   logic [ENT_W-1:0]      pop_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      phase_increment_in = phase_increment_ff;
      mod_depth_in       = mod_depth_ff;
      if (csr_write) begin
         case (csr_index)
            REG_PHASE_INCREMENT: phase_increment_in = csr_data[INCR_BITS-1:0];
            REG_MOD_DEPTH:       mod_depth_in       = csr_data[DEPTH_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff <= PHASE_INCREMENT_RESET;
         mod_depth_ff       <= MOD_DEPTH_RESET;
      end else begin
         phase_increment_ff <= phase_increment_in;
         mod_depth_ff       <= mod_depth_in;
      end
   end

   lfota_front #(
      .PHASE_BITS       (PHASE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .IDX_W            (IDX_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .phase_increment (phase_increment_ff),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   lfota_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lfota_back #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .IDX_W            (IDX_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .mod_depth     (mod_depth_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

endmodule
